>>> design/cbr_pkg.sv
`timescale 1ns / 1ps
package cbr_pkg;

  localparam int CW      = 11;  // count register and tally width
  localparam int SUM_W   = 48;  // quantile sum width
  localparam int VAL_W   = 32;  // stored sample width
  localparam int POS_W   = 10;
  localparam int Q_DEPTH = 4;

  localparam logic [CW-1:0] TALLY_MAX = '1;

  // action codes on the input
  localparam logic [2:0] ACT_LOAD_Y  = 3'd0;
  localparam logic [2:0] ACT_LOAD_X  = 3'd1;
  localparam logic [2:0] ACT_LOAD_Z  = 3'd2;
  localparam logic [2:0] ACT_DRAW_X  = 3'd3;
  localparam logic [2:0] ACT_DRAW_Z  = 3'd4;
  localparam logic [2:0] ACT_COMPUTE = 3'd5;

  // command kinds between front and back
  localparam logic [2:0] K_LOAD_Y   = 3'd0;
  localparam logic [2:0] K_LOAD_X   = 3'd1;
  localparam logic [2:0] K_LOAD_Z   = 3'd2;
  localparam logic [2:0] K_DRAW_X   = 3'd3;
  localparam logic [2:0] K_DRAW_Z   = 3'd4;
  localparam logic [2:0] K_COMPUTE  = 3'd5;
  localparam logic [2:0] K_BAD_DRAW = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_COUNT = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  localparam logic [1:0] CFG_Y_COUNT = 2'd0;
  localparam logic [1:0] CFG_X_COUNT = 2'd1;
  localparam logic [1:0] CFG_Z_COUNT = 2'd2;

  typedef struct packed {
    logic [2:0]       kind;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] pos;
  } cmd_t;

  typedef struct packed {
    logic [CW-1:0] n1;
    logic [CW-1:0] n2;
    logic [CW-1:0] n3;
  } counts_t;

endpackage

>>> design/cbr_fifo.sv
`timescale 1ns / 1ps
module cbr_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cbr_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          pop_valid,
  output cbr_pkg::cmd_t pop_cmd
);
  import cbr_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);

  cmd_t          entries [Q_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   fill;
  logic          do_push;
  logic          do_pop;

  assign full      = (fill == (PW+1)'(Q_DEPTH));
  assign pop_valid = (fill != '0);
  assign pop_cmd   = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) fill <= fill + 1'b1;
      else if (!do_push && do_pop) fill <= fill - 1'b1;
    end
  end

endmodule

>>> design/cbr_front.sv
`timescale 1ns / 1ps
module cbr_front #(
  parameter int MAX_SAMPLES  = 1024,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [10:0]      cfg_data,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [47:0]      s_tdata,
  input  logic [7:0]       s_tuser,
  output logic             push,
  output cbr_pkg::cmd_t    push_cmd,
  input  logic             q_full,
  output cbr_pkg::counts_t counts
);
  import cbr_pkg::*;

  localparam int SWE = (SAMPLE_WIDTH < VAL_W) ? SAMPLE_WIDTH : VAL_W;

  logic [CW-1:0]          y_count;
  logic [CW-1:0]          x_count;
  logic [CW-1:0]          z_count;
  logic [2:0]             action;
  logic signed [SWE-1:0]  raw;
  logic [POS_W-1:0]       pos;
  logic                   keep;
  logic [2:0]             kind;

  function automatic logic [CW-1:0] eff(input logic [CW-1:0] r);
    if (r == '0) return CW'(1);
    if (32'(r) > MAX_SAMPLES) return CW'(MAX_SAMPLES);
    return r;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      y_count <= CW'(1);
      x_count <= CW'(1);
      z_count <= CW'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_Y_COUNT: y_count <= cfg_data;
        CFG_X_COUNT: x_count <= cfg_data;
        CFG_Z_COUNT: z_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign counts.n1 = eff(y_count);
  assign counts.n2 = eff(x_count);
  assign counts.n3 = eff(z_count);

  assign action   = s_tuser[2:0];
  assign raw      = s_tdata[SWE-1:0];
  assign pos      = s_tdata[41:32];
  assign s_tready = !q_full;

  // classify: drop loads past the store and unknown actions, flag bad draws
  always_comb begin
    keep = 1'b1;
    kind = K_COMPUTE;
    unique case (action)
      ACT_LOAD_Y: begin kind = K_LOAD_Y; keep = (32'(pos) < MAX_SAMPLES); end
      ACT_LOAD_X: begin kind = K_LOAD_X; keep = (32'(pos) < MAX_SAMPLES); end
      ACT_LOAD_Z: begin kind = K_LOAD_Z; keep = (32'(pos) < MAX_SAMPLES); end
      ACT_DRAW_X: kind = (CW'(pos) < counts.n2) ? K_DRAW_X : K_BAD_DRAW;
      ACT_DRAW_Z: kind = (CW'(pos) < counts.n3) ? K_DRAW_Z : K_BAD_DRAW;
      ACT_COMPUTE: kind = K_COMPUTE;
      default: keep = 1'b0;
    endcase
  end

  assign push           = s_tvalid && s_tready && keep;
  assign push_cmd.kind  = kind;
  assign push_cmd.value = VAL_W'(raw);
  assign push_cmd.pos   = pos;

endmodule

>>> design/cbr_div.sv
`timescale 1ns / 1ps
module cbr_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [cbr_pkg::SUM_W-1:0] dividend,
  input  logic [cbr_pkg::CW-1:0]    divisor,
  output logic                      done,
  output logic [cbr_pkg::SUM_W-1:0] quot,
  output logic [cbr_pkg::CW-1:0]    rem
);
  import cbr_pkg::*;

  localparam int NB = $clog2(SUM_W + 1);

  logic [NB-1:0] steps;
  logic [CW-1:0] dvs;
  logic [CW:0]   trial;
  logic          fits;

  assign trial = {rem, quot[SUM_W-1]};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        steps <= NB'(SUM_W);
        quot  <= dividend;
        rem   <= '0;
        dvs   <= divisor;
      end else if (steps != '0) begin
        // one quotient bit per cycle
        rem   <= fits ? CW'(trial - {1'b0, dvs}) : CW'(trial);
        quot  <= {quot[SUM_W-2:0], fits};
        steps <= steps - 1'b1;
        done  <= (steps == NB'(1));
      end
    end
  end

endmodule

>>> design/cbr_back.sv
`timescale 1ns / 1ps
module cbr_back #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  cbr_pkg::cmd_t    cmd,
  output logic             cmd_ready,
  input  cbr_pkg::counts_t counts,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      estimate,
  output logic [1:0]       status
);
  import cbr_pkg::*;

  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int IW = (AW > CW) ? AW : CW;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CLR    = 5'd1;
  localparam logic [4:0] S_DX_RD  = 5'd2;
  localparam logic [4:0] S_DX_WR  = 5'd3;
  localparam logic [4:0] S_DZ_RD  = 5'd4;
  localparam logic [4:0] S_DZ_WR  = 5'd5;
  localparam logic [4:0] S_CU_RD  = 5'd6;
  localparam logic [4:0] S_CU_WR  = 5'd7;
  localparam logic [4:0] S_XL_RD  = 5'd8;
  localparam logic [4:0] S_XL_W   = 5'd9;
  localparam logic [4:0] S_SR_CHK = 5'd10;
  localparam logic [4:0] S_SR_RD  = 5'd11;
  localparam logic [4:0] S_SR_W   = 5'd12;
  localparam logic [4:0] S_C_SEL  = 5'd13;
  localparam logic [4:0] S_C_RD   = 5'd14;
  localparam logic [4:0] S_C_W    = 5'd15;
  localparam logic [4:0] S_MUL    = 5'd16;
  localparam logic [4:0] S_DV_GO  = 5'd17;
  localparam logic [4:0] S_DV_W   = 5'd18;
  localparam logic [4:0] S_Y_RD   = 5'd19;
  localparam logic [4:0] S_Y_W    = 5'd20;
  localparam logic [4:0] S_MN_GO  = 5'd21;
  localparam logic [4:0] S_MN_W   = 5'd22;
  localparam logic [4:0] S_OUT    = 5'd23;

  logic [VAL_W-1:0] y_mem   [MAX_SAMPLES];
  logic [VAL_W-1:0] x_mem   [MAX_SAMPLES];
  logic [VAL_W-1:0] z_mem   [MAX_SAMPLES];
  logic [VAL_W-1:0] rx_mem  [MAX_SAMPLES];
  logic [CW-1:0]    cnt_mem [MAX_SAMPLES];
  logic [CW-1:0]    cum_mem [MAX_SAMPLES];

  logic [VAL_W-1:0]        y_rd, x_rd, z_rd, rx_rd;
  logic [CW-1:0]           cnt_rd, cum_rd;
  logic [4:0]              state;
  logic [IW-1:0]           idx;
  logic [AW-1:0]           pend;
  logic [AW-1:0]           q_addr;
  logic [CW-1:0]           xt, zt, run, lo, hi, mid, c;
  logic                    bad;
  logic signed [SUM_W-1:0] sum;
  logic signed [VAL_W-1:0] xv;
  logic [2*CW-1:0]         prod;
  logic                    div_start, div_done;
  logic [SUM_W-1:0]        div_num, div_quot;
  logic [CW-1:0]           div_den, div_rem;
  logic [SUM_W-1:0]        qc;
  logic [SUM_W-1:0]        qsel;
  logic [CW-1:0]           run_next;
  logic                    cnt_we;
  logic [AW-1:0]           cnt_wa, cnt_ra;
  logic [CW-1:0]           cnt_wd;
  logic                    take;
  logic [31:0]             res_est;
  logic [1:0]              res_st;
  logic                    out_load;

  assign take      = (state == S_IDLE) && cmd_valid;
  assign cmd_ready = (state == S_IDLE);
  assign run_next  = run + cnt_rd;
  assign out_load  = (state == S_OUT) && (!out_valid || out_ready);

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (take && cmd.kind == K_LOAD_Y) y_mem[AW'(cmd.pos)] <= cmd.value;
    y_rd <= y_mem[q_addr];
  end

  always_ff @(posedge clk) begin
    if (take && cmd.kind == K_LOAD_X) x_mem[AW'(cmd.pos)] <= cmd.value;
    x_rd <= x_mem[pend];
  end

  always_ff @(posedge clk) begin
    if (take && cmd.kind == K_LOAD_Z) z_mem[AW'(cmd.pos)] <= cmd.value;
    z_rd <= z_mem[AW'(mid)];
  end

  always_ff @(posedge clk) begin
    if (state == S_DX_WR && 32'(xt) < MAX_SAMPLES) rx_mem[AW'(xt)] <= x_rd;
    rx_rd <= rx_mem[AW'(idx)];
  end

  always_ff @(posedge clk) begin
    if (state == S_CU_WR) cum_mem[AW'(idx)] <= run_next;
    cum_rd <= cum_mem[AW'(lo - 1'b1)];
  end

  always_comb begin
    cnt_we = (state == S_CLR) || (state == S_DZ_WR);
    cnt_wa = (state == S_CLR) ? AW'(idx) : pend;
    cnt_wd = (state == S_CLR) ? '0 : ((cnt_rd == TALLY_MAX) ? cnt_rd : cnt_rd + 1'b1);
    cnt_ra = (state == S_CU_RD) ? AW'(idx) : pend;
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_rd <= cnt_mem[cnt_ra];
  end

  // shared divider: quantile index, then the mean
  assign div_start = (state == S_DV_GO) || (state == S_MN_GO);
  assign div_num   = (state == S_MN_GO) ? SUM_W'(sum < 0 ? -sum : sum) : SUM_W'(prod);
  assign div_den   = (state == S_MN_GO) ? counts.n2 : counts.n3;

  cbr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign qc = div_quot + SUM_W'(div_rem != '0);

  always_comb begin
    priority if (qc == '0) qsel = SUM_W'(1);
    else if (qc > SUM_W'(counts.n1)) qsel = SUM_W'(counts.n1);
    else qsel = qc;
  end

  // result register: load only when free, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      estimate <= res_est;
      status   <= res_st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      idx       <= '0;
      xt        <= '0;
      zt        <= '0;
      bad       <= 1'b0;
      sum       <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            pend <= AW'(cmd.pos);
            unique case (cmd.kind)
              K_DRAW_X: state <= S_DX_RD;
              K_DRAW_Z: state <= S_DZ_RD;
              K_BAD_DRAW: bad <= 1'b1;
              K_COMPUTE: begin
                res_est <= '0;
                idx     <= '0;
                run     <= '0;
                priority if (bad) begin
                  res_st <= ST_BAD;
                  state  <= S_OUT;
                end else if (xt != counts.n2 || zt != counts.n3) begin
                  res_st <= ST_COUNT;
                  state  <= S_OUT;
                end else begin
                  res_st <= ST_OK;
                  state  <= S_CU_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_DX_RD: state <= S_DX_WR;
        S_DX_WR: begin
          if (xt != TALLY_MAX) xt <= xt + 1'b1;
          state <= S_IDLE;
        end
        S_DZ_RD: state <= S_DZ_WR;
        S_DZ_WR: begin
          if (zt != TALLY_MAX) zt <= zt + 1'b1;
          state <= S_IDLE;
        end
        S_CU_RD: state <= S_CU_WR;
        S_CU_WR: begin
          run <= run_next;
          if (idx == IW'(counts.n3 - 1'b1)) begin
            idx   <= '0;
            sum   <= '0;
            state <= S_XL_RD;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_CU_RD;
          end
        end
        S_XL_RD: state <= S_XL_W;
        S_XL_W: begin
          xv    <= rx_rd;
          lo    <= '0;
          hi    <= counts.n3;
          state <= S_SR_CHK;
        end
        S_SR_CHK: begin
          if (lo < hi) begin
            mid   <= CW'(({1'b0, lo} + {1'b0, hi}) >> 1);
            state <= S_SR_RD;
          end else begin
            state <= S_C_SEL;
          end
        end
        S_SR_RD: state <= S_SR_W;
        S_SR_W: begin
          // first Z not less than X
          if ($signed(z_rd) < xv) lo <= mid + 1'b1;
          else hi <= mid;
          state <= S_SR_CHK;
        end
        S_C_SEL: begin
          priority if (lo == '0) begin
            c     <= '0;
            state <= S_MUL;
          end else if (lo >= counts.n3) begin
            c     <= counts.n3;
            state <= S_MUL;
          end else begin
            state <= S_C_RD;
          end
        end
        S_C_RD: state <= S_C_W;
        S_C_W: begin
          c     <= cum_rd;
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= c * counts.n1;
          state <= S_DV_GO;
        end
        S_DV_GO: state <= S_DV_W;
        S_DV_W: begin
          if (div_done) begin
            q_addr <= AW'(qsel - 1'b1);
            state  <= S_Y_RD;
          end
        end
        S_Y_RD: state <= S_Y_W;
        S_Y_W: begin
          sum <= sum + SUM_W'($signed(y_rd));
          if (idx == IW'(counts.n2 - 1'b1)) begin
            state <= S_MN_GO;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_XL_RD;
          end
        end
        S_MN_GO: state <= S_MN_W;
        S_MN_W: begin
          if (div_done) begin
            res_est <= (sum < 0) ? 32'(-div_quot) : 32'(div_quot);
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (out_load) begin
            xt    <= '0;
            zt    <= '0;
            bad   <= 1'b0;
            sum   <= '0;
            idx   <= '0;
            state <= S_CLR;
          end
        end
        S_CLR: begin
          if (idx == IW'(MAX_SAMPLES - 1)) begin
            idx   <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/cic_bootstrap_replication.sv
`timescale 1ns / 1ps
// channel   direction  handshake             payload
// s_*       in         s_tvalid / s_tready   tdata value, position; tuser action
// m_*       out        m_tvalid / m_tready   tdata estimate, status
// cfg_*     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// A load is written in idle; a draw passes read and write states. A compute
// with ST_OK status walks the Z counts (read and write state per Z sample),
// then per resampled X a binary search (check, read and compare states per
// step) and a serial divide, then a divide for the mean. Every compute ends
// with a clearing pass over the Z count memory; after reset the same pass runs
// before queue items are taken. A 4-entry queue takes items while the back
// works; the result register lets the next item start while a result waits.
module cic_bootstrap_replication #(
  parameter int MAX_SAMPLES  = 1024,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // sample_value[31:0], position[41:32]
  input  logic [7:0]  s_tuser,  // action[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata   // estimate[31:0], status[33:32]
);
  import cbr_pkg::*;

  logic    push;
  cmd_t    push_cmd;
  logic    q_full;
  logic    pop;
  logic    pop_valid;
  cmd_t    pop_cmd;
  counts_t counts;
  logic [31:0] estimate;
  logic [1:0]  status;

  cbr_front #(
    .MAX_SAMPLES  (MAX_SAMPLES),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .push      (push),
    .push_cmd  (push_cmd),
    .q_full    (q_full),
    .counts    (counts)
  );

  cbr_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd)
  );

  cbr_back #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (pop_valid),
    .cmd       (pop_cmd),
    .cmd_ready (pop),
    .counts    (counts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .estimate  (estimate),
    .status    (status)
  );

  assign m_tdata = {6'd0, status, estimate};

endmodule

>>> design/cbr_checker.sv
`timescale 1ns / 1ps
module cbr_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [1:0]  cfg_index,
  input logic [10:0] cfg_data,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [47:0] s_tdata,
  input logic [7:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);
  import cbr_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped or changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[33:32] != 2'd3)
    else $error("undefined status code");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[33:32] != ST_OK |-> m_tdata[31:0] == 32'd0)
    else $error("estimate not zero on error status");

  a_reset_out: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result shown right after reset");

endmodule

bind cic_bootstrap_replication cbr_checker u_chk (.*);
